[design/fce_pkg.sv]
package fce_pkg;

    localparam int ADDR_W     = 11;
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int IVL_W      = 22;
    localparam int PROD_W     = LEVEL_W + IVL_W;
    localparam int CNT_W      = 5;
    localparam int MAX_RESULTS = 64;
    localparam int K_W        = 7;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_UPDATE  = 3'd0,
        ST_STORED  = 3'd1,
        ST_NODIFF  = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOTHING = 3'd4
    } status_t;

    // Input action codes.
    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CHK,
        S_ADD_SCAN,
        S_ADD_DIV,
        S_ADD_WR,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_DIV,
        S_TICK_MUL,
        S_TICK_UPD,
        S_TICK_END
    } state_t;

    // Which result the output register takes.
    typedef enum logic [1:0] {
        EM_NONE,
        EM_PEND,
        EM_PEND_LAST,
        EM_CODE
    } emit_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic               down;
        logic [IVL_W-1:0]   interval;
        logic [TIME_W-1:0]  due;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    idx_inc;
        logic    div_add;
        logic    div_tick;
        logic    add_wr;
        logic    clr_valid;
        logic    steps_direct;
        logic    steps_div;
        logic    mul;
        logic    upd;
        emit_t   emit;
        status_t code;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_fire;
        logic is_tick;
        logic levels_equal;
        logic valid_cur;
        logic idx_last;
        logic walk_end;
        logic rem_zero;
        logic not_due;
        logic direct;
        logic div_done;
        logic out_free;
        logic pend_valid;
    } sts_t;

endpackage

[design/fce_in_if.sv]
interface fce_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [fce_pkg::ADDR_W-1:0]    channel_address;
    logic [fce_pkg::LEVEL_W-1:0]   start_level;
    logic [fce_pkg::LEVEL_W-1:0]   target_level;
    logic [fce_pkg::TIME_W-1:0]    time_ms;

    modport source (output valid, action, channel_address, start_level, target_level,
                    time_ms, input ready);
    modport sink (input valid, action, channel_address, start_level, target_level,
                  time_ms, output ready);
endinterface

[design/fce_out_if.sv]
interface fce_out_if;
    logic                          valid;
    logic                          ready;
    fce_pkg::status_t              status;
    logic [fce_pkg::ADDR_W-1:0]    out_address;
    logic [fce_pkg::LEVEL_W-1:0]   out_level;
    logic                          last;

    modport source (output valid, status, out_address, out_level, last, input ready);
    modport sink (input valid, status, out_address, out_level, last, output ready);
endinterface

[design/fce_cfg_if.sv]
interface fce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fce_pkg::IVL_W-1:0]   fade_time_ms;

    modport source (output valid, fade_time_ms, input ready);
    modport sink (input valid, fade_time_ms, output ready);
endinterface

[design/fce_div.sv]
module fce_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fce_pkg::IVL_W-1:0]  rem_init,
    input  logic [fce_pkg::IVL_W-1:0]  bits,
    input  logic [fce_pkg::CNT_W-1:0]  count,
    input  logic [fce_pkg::IVL_W-1:0]  divisor,
    output logic                       done,
    output logic [fce_pkg::IVL_W-1:0]  quot
);
    import fce_pkg::*;

    logic [IVL_W-1:0] rem_reg;
    logic [IVL_W-1:0] bits_reg;
    logic [IVL_W-1:0] quot_reg;
    logic [IVL_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [IVL_W:0]   trial;
    logic             take;
    logic [IVL_W:0]   diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, bits_reg[IVL_W-1]};
    assign take  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= bits;
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff[IVL_W-1:0] : trial[IVL_W-1:0];
            bits_reg <= {bits_reg[IVL_W-2:0], 1'b0};
            quot_reg <= {quot_reg[IVL_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[design/fce_ctrl.sv]
module fce_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  fce_pkg::sts_t  sts,
    output fce_pkg::cmd_t  cmd
);
    import fce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (sts.in_fire)
                    state_next = sts.is_tick ? S_TICK_RD : S_ADD_CHK;
            S_ADD_CHK:
                if (!sts.levels_equal)
                    state_next = S_ADD_SCAN;
                else if (sts.out_free)
                    state_next = S_IDLE;
            S_ADD_SCAN:
                if (!sts.valid_cur)
                    state_next = S_ADD_DIV;
                else if (sts.idx_last && sts.out_free)
                    state_next = S_IDLE;
            S_ADD_DIV:
                if (sts.div_done)
                    state_next = S_ADD_WR;
            S_ADD_WR:
                if (sts.out_free)
                    state_next = S_IDLE;
            S_TICK_RD:
                if (sts.walk_end)
                    state_next = S_TICK_END;
                else if (sts.valid_cur)
                    state_next = S_TICK_EVAL;
            S_TICK_EVAL:
                if (sts.rem_zero || sts.not_due)
                    state_next = S_TICK_RD;
                else if (sts.direct)
                    state_next = S_TICK_MUL;
                else
                    state_next = S_TICK_DIV;
            S_TICK_DIV:
                if (sts.div_done)
                    state_next = S_TICK_MUL;
            S_TICK_MUL:
                state_next = S_TICK_UPD;
            S_TICK_UPD:
                if (!sts.pend_valid || sts.out_free)
                    state_next = S_TICK_RD;
            S_TICK_END:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd      = '0;
        cmd.emit = EM_NONE;
        cmd.code = ST_UPDATE;
        case (state_reg)
            S_IDLE:
                cmd.in_ready = 1'b1;
            S_ADD_CHK:
                if (sts.levels_equal && sts.out_free)
                begin
                    cmd.emit = EM_CODE;
                    cmd.code = ST_NODIFF;
                end
            S_ADD_SCAN:
                if (!sts.valid_cur)
                    cmd.div_add = 1'b1;
                else if (!sts.idx_last)
                    cmd.idx_inc = 1'b1;
                else if (sts.out_free)
                begin
                    cmd.emit = EM_CODE;
                    cmd.code = ST_FULL;
                end
            S_ADD_WR:
                if (sts.out_free)
                begin
                    cmd.add_wr = 1'b1;
                    cmd.emit   = EM_CODE;
                    cmd.code   = ST_STORED;
                end
            S_TICK_RD:
                if (!sts.walk_end && !sts.valid_cur)
                    cmd.idx_inc = 1'b1;
            S_TICK_EVAL:
                if (sts.rem_zero)
                begin
                    cmd.clr_valid = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
                else if (sts.not_due)
                    cmd.idx_inc = 1'b1;
                else if (sts.direct)
                    cmd.steps_direct = 1'b1;
                else
                    cmd.div_tick = 1'b1;
            S_TICK_DIV:
                if (sts.div_done)
                    cmd.steps_div = 1'b1;
            S_TICK_MUL:
                cmd.mul = 1'b1;
            S_TICK_UPD:
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.upd     = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (sts.pend_valid)
                        cmd.emit = EM_PEND;
                end
            S_TICK_END:
                if (sts.out_free)
                begin
                    if (sts.pend_valid)
                        cmd.emit = EM_PEND_LAST;
                    else
                    begin
                        cmd.emit = EM_CODE;
                        cmd.code = ST_NOTHING;
                    end
                end
            default:
                cmd = '0;
        endcase
    end

endmodule

[design/fce_dp.sv]
module fce_dp #(
    parameter int MAX_FADES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    fce_in_if.sink         in_ch,
    fce_out_if.source      out_ch,
    fce_cfg_if.sink        cfg_ch,
    input  fce_pkg::cmd_t  cmd,
    output fce_pkg::sts_t  sts
);
    import fce_pkg::*;

    localparam int AW    = (MAX_FADES > 1) ? $clog2(MAX_FADES) : 1;
    localparam int IDX_W = $clog2(MAX_FADES + 1);

    // Fade table storage and its valid bits.
    entry_t mem [MAX_FADES];
    entry_t rd_reg;
    logic [MAX_FADES-1:0] valid_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W-1:0] target_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [IVL_W-1:0]   fade_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [K_W-1:0]     k_reg;
    logic [LEVEL_W-1:0] steps_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               pend_valid_reg;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic [LEVEL_W-1:0] pend_level_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_last_reg;

    logic [AW-1:0]      widx;
    logic               in_fire;
    logic               out_free;
    logic [LEVEL_W-1:0] add_diff;
    logic [LEVEL_W-1:0] remaining;
    logic [TIME_W-1:0]  dm1;
    logic [TIME_W-1:0]  ivl_shift;
    logic               direct;
    logic               div_start;
    logic [IVL_W-1:0]   div_rem;
    logic [IVL_W-1:0]   div_bits;
    logic [CNT_W-1:0]   div_count;
    logic [IVL_W-1:0]   div_divisor;
    logic               div_done;
    logic [IVL_W-1:0]   div_quot;
    logic [LEVEL_W:0]   n_steps;
    logic [LEVEL_W-1:0] level_next;
    logic               mem_we;
    entry_t             mem_wdata;

    assign widx     = idx_reg[AW-1:0];
    assign in_fire  = in_ch.valid && cmd.in_ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready  = cmd.in_ready;
    assign cfg_ch.ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fade_reg <= IVL_W'(1000);
        else if (cfg_ch.valid)
            fade_reg <= cfg_ch.fade_time_ms;
    end

    // Latch the input item on its transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg   <= in_ch.channel_address;
            start_reg  <= in_ch.start_level;
            target_reg <= in_ch.target_level;
            now_reg    <= in_ch.time_ms;
        end
    end

    // Distance between the two add levels.
    assign add_diff = (target_reg > start_reg) ? (target_reg - start_reg)
                                               : (start_reg - target_reg);

    // Steps still to go and time elapsed for the entry under examination.
    assign remaining = (rd_reg.target > rd_reg.level) ? (rd_reg.target - rd_reg.level)
                                                      : (rd_reg.level - rd_reg.target);
    assign dm1       = now_reg - rd_reg.due - TIME_W'(1);
    assign ivl_shift = {2'b00, rd_reg.interval, 8'h00};
    assign direct    = (rd_reg.interval == '0) || (dm1 >= ivl_shift);

    // The divider serves both the add interval and the catch-up step count.
    assign div_start   = cmd.div_add || cmd.div_tick;
    assign div_rem     = cmd.div_tick ? IVL_W'(dm1[TIME_W-1:8]) : '0;
    assign div_bits    = cmd.div_tick ? {dm1[7:0], {(IVL_W-8){1'b0}}} : fade_reg;
    assign div_count   = cmd.div_tick ? CNT_W'(8) : CNT_W'(IVL_W);
    assign div_divisor = cmd.div_tick ? rd_reg.interval : IVL_W'(add_diff);

    fce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .bits     (div_bits),
        .count    (div_count),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign n_steps    = {1'b0, div_quot[LEVEL_W-1:0]} + (LEVEL_W+1)'(1);
    assign level_next = rd_reg.down ? (rd_reg.level - steps_reg)
                                    : (rd_reg.level + steps_reg);

    // Memory write data: a new fade or an advanced entry.
    always_comb
    begin
        mem_we    = cmd.add_wr || cmd.upd;
        mem_wdata = rd_reg;
        if (cmd.add_wr)
        begin
            mem_wdata.address  = addr_reg;
            mem_wdata.level    = start_reg;
            mem_wdata.target   = target_reg;
            mem_wdata.down     = target_reg < start_reg;
            mem_wdata.interval = div_quot;
            mem_wdata.due      = now_reg + TIME_W'(div_quot);
        end
        else
        begin
            mem_wdata.level = level_next;
            mem_wdata.due   = rd_reg.due + TIME_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[widx] <= mem_wdata;
        rd_reg <= mem[widx];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.add_wr)
            valid_reg[widx] <= 1'b1;
        else if (cmd.clr_valid || (cmd.upd && (level_next == rd_reg.target)))
            valid_reg[widx] <= 1'b0;
    end

    // Walk index, result count and the held-back tick result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                idx_reg        <= '0;
                k_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                    idx_reg <= idx_reg + IDX_W'(1);
                if (cmd.upd)
                begin
                    k_reg          <= k_reg + K_W'(1);
                    pend_valid_reg <= 1'b1;
                end
                else if (cmd.emit == EM_PEND_LAST)
                    pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.steps_direct)
            steps_reg <= remaining;
        else if (cmd.steps_div)
            steps_reg <= (n_steps < {1'b0, remaining}) ? n_steps[LEVEL_W-1:0] : remaining;
        if (cmd.mul)
            prod_reg <= PROD_W'(steps_reg) * PROD_W'(rd_reg.interval);
        if (cmd.upd)
        begin
            pend_addr_reg  <= rd_reg.address;
            pend_level_reg <= level_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit != EM_NONE)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EM_PEND, EM_PEND_LAST:
            begin
                out_status_reg <= ST_UPDATE;
                out_addr_reg   <= pend_addr_reg;
                out_level_reg  <= pend_level_reg;
                out_last_reg   <= (cmd.emit == EM_PEND_LAST);
            end
            EM_CODE:
            begin
                out_status_reg <= cmd.code;
                out_addr_reg   <= (cmd.code == ST_NOTHING) ? '0 : addr_reg;
                out_level_reg  <= '0;
                out_last_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.out_address = out_addr_reg;
    assign out_ch.out_level   = out_level_reg;
    assign out_ch.last        = out_last_reg;

    // Status to the controller.
    always_comb
    begin
        sts              = '0;
        sts.in_fire      = in_fire;
        sts.is_tick      = (in_ch.action == ACT_TICK);
        sts.levels_equal = (start_reg == target_reg);
        sts.valid_cur    = valid_reg[widx];
        sts.idx_last     = (idx_reg == IDX_W'(MAX_FADES - 1));
        sts.walk_end     = (idx_reg == IDX_W'(MAX_FADES)) || (k_reg == K_W'(MAX_RESULTS));
        sts.rem_zero     = (remaining == '0);
        sts.not_due      = !(rd_reg.due < now_reg);
        sts.direct       = direct;
        sts.div_done     = div_done;
        sts.out_free     = out_free;
        sts.pend_valid   = pend_valid_reg;
    end

    // A level update takes at least one step and never passes the target.
    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (steps_reg != '0) && (steps_reg <= remaining))
        else $error("fade step count out of range");

    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |-> out_free)
        else $error("result loaded over an untaken result");

    // A stored fade marks its entry in use.
    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_wr |=> valid_reg[$past(widx)])
        else $error("stored fade entry not marked valid");

    // The walk never runs past the table on an add.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_add || cmd.add_wr) |-> (idx_reg < IDX_W'(MAX_FADES)))
        else $error("free entry search ran past the table");

endmodule

[design/channel_fade_engine_core.sv]
// Channel fade engine: a table of up to MAX_FADES linear level fades.
// in_ch carries one item per transfer. An add item (action 0) stores a fade
// for a channel and answers with one result: fade stored, no difference or
// table full. A tick item (action 1) brings the current time in ms; every
// active fade takes all whole steps that are due, until MAX_RESULTS fades
// have moved, and the tick answers with one level update per fade that
// moved (last set on the final one), or a single "nothing due" result.
// cfg_ch writes the fade time, which applies to fades added afterwards.
// An equal-level add answers from the check state, and a full table after
// a scan of every entry. A stored add scans the occupied entries ahead of
// the first free one, then runs the 22-bit interval divide one bit per
// cycle. A tick walks the table: it reads each entry, checks each active
// one for being due, and for a due entry gets the step count (through the
// 8-step divider when the catch-up count needs it), multiplies and updates;
// when the walk ends it closes with the last result.
// One item is in work at a time; the next is taken once the last result of
// the previous one has been loaded into the output register.
// Reset clears the fade table (valid bits only), and sets the fade time to
// 1000 ms. When the receiver stalls out_ch, results wait in the output
// register and the table walk pauses until the next result can move.
module channel_fade_engine_core #(
    parameter int MAX_FADES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    fce_in_if.sink     in_ch,
    fce_out_if.source  out_ch,
    fce_cfg_if.sink    cfg_ch
);
    import fce_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    fce_dp #(
        .MAX_FADES (MAX_FADES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fce_pkg::*;

    localparam int NUM_FADES  = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   channel_address;
        logic [LEVEL_W-1:0]  start_level;
        logic [LEVEL_W-1:0]  target_level;
        logic [TIME_W-1:0]   time_ms;
    } fade_item_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   out_address;
        logic [LEVEL_W-1:0]  out_level;
        logic                last;
    } fade_result_t;

    logic clk;
    logic rst_n;

    fce_in_if  in_ch ();
    fce_out_if out_ch ();
    fce_cfg_if cfg_ch ();

    channel_fade_engine_core #(.MAX_FADES(NUM_FADES)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state: a shadow copy of the fade table and the fade time.
    logic [IVL_W-1:0]   fade_time;
    logic               tbl_valid    [NUM_FADES];
    logic [ADDR_W-1:0]  tbl_address  [NUM_FADES];
    logic [LEVEL_W-1:0] tbl_level    [NUM_FADES];
    logic [LEVEL_W-1:0] tbl_target   [NUM_FADES];
    logic               tbl_down     [NUM_FADES];
    logic [IVL_W-1:0]   tbl_interval [NUM_FADES];
    logic [TIME_W-1:0]  tbl_due      [NUM_FADES];

    fade_item_t   pending_items[$];
    fade_result_t expected_results[$];
    int  error_count;
    int  results_seen;
    int  ticks_sent;
    int  adds_sent;
    int  idle_cycles;
    bit  stimulus_done;

    // Clock generation.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic fade_result_t make_result(status_t st, logic [ADDR_W-1:0] addr,
                                                 logic [LEVEL_W-1:0] lvl, logic lst);
        fade_result_t r;
        r.status      = st;
        r.out_address = addr;
        r.out_level   = lvl;
        r.last        = lst;
        return r;
    endfunction

    // Work out the results of one accepted item and update the shadow table.
    task automatic predict_fades(input fade_item_t it);
        int slot;
        int count;
        logic [8:0]  remaining;
        logic [8:0]  steps;
        logic [31:0] lag;
        logic [31:0] n;
        logic [8:0]  lvl;
        slot  = -1;
        count = 0;
        if (it.action == ACT_ADD) begin
            if (it.start_level == it.target_level) begin
                expected_results.push_back(make_result(ST_NODIFF, it.channel_address,
                                                       '0, 1'b1));
            end
            else begin
                for (int i = 0; i < NUM_FADES; i++)
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                if (slot < 0) begin
                    expected_results.push_back(make_result(ST_FULL, it.channel_address,
                                                           '0, 1'b1));
                end
                else begin
                    remaining = (it.target_level > it.start_level)
                              ? it.target_level - it.start_level
                              : it.start_level - it.target_level;
                    tbl_valid[slot]    = 1'b1;
                    tbl_address[slot]  = it.channel_address;
                    tbl_level[slot]    = it.start_level;
                    tbl_target[slot]   = it.target_level;
                    tbl_down[slot]     = it.target_level < it.start_level;
                    tbl_interval[slot] = fade_time / remaining;
                    tbl_due[slot]      = it.time_ms + tbl_interval[slot];
                    expected_results.push_back(make_result(ST_STORED, it.channel_address,
                                                           '0, 1'b1));
                end
            end
        end
        else begin
            for (int i = 0; i < NUM_FADES && count < MAX_RESULTS; i++) begin
                if (tbl_valid[i]) begin
                    remaining = (tbl_target[i] > tbl_level[i])
                              ? tbl_target[i] - tbl_level[i]
                              : tbl_level[i] - tbl_target[i];
                    if (remaining == 0)
                        tbl_valid[i] = 1'b0;
                    else if (tbl_due[i] < it.time_ms) begin
                        lag = it.time_ms - tbl_due[i];
                        if (tbl_interval[i] == 0)
                            n = remaining;
                        else
                            n = (lag - 1) / tbl_interval[i] + 1;
                        steps = (n < remaining) ? n[8:0] : remaining;
                        lvl = tbl_down[i] ? tbl_level[i] - steps : tbl_level[i] + steps;
                        tbl_level[i] = lvl[7:0];
                        tbl_due[i]   = tbl_due[i] + steps * tbl_interval[i];
                        if (tbl_level[i] == tbl_target[i])
                            tbl_valid[i] = 1'b0;
                        expected_results.push_back(make_result(ST_UPDATE, tbl_address[i],
                                                               tbl_level[i], 1'b0));
                        count++;
                    end
                end
            end
            if (count == 0)
                expected_results.push_back(make_result(ST_NOTHING, '0, '0, 1'b1));
            else
                expected_results[$].last = 1'b1;
        end
    endtask

    // Input driver: each item waits a random gap before being offered.
    int in_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid           <= 1'b0;
            in_ch.action          <= ACT_ADD;
            in_ch.channel_address <= '0;
            in_ch.start_level     <= '0;
            in_ch.target_level    <= '0;
            in_ch.time_ms         <= '0;
            in_gap                <= $urandom_range(0, 19);
        end
        else if (in_ch.valid && !in_ch.ready) begin
            // Hold the item until the transfer completes.
        end
        else if (in_gap > 0) begin
            in_ch.valid <= 1'b0;
            in_gap      <= in_gap - 1;
        end
        else if (pending_items.size() > 0) begin
            fade_item_t it;
            it = pending_items.pop_front();
            predict_fades(it);
            in_ch.valid           <= 1'b1;
            in_ch.action          <= it.action;
            in_ch.channel_address <= it.channel_address;
            in_ch.start_level     <= it.start_level;
            in_ch.target_level    <= it.target_level;
            in_ch.time_ms         <= it.time_ms;
            in_gap                <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end
        else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output monitor with random back-pressure.
    int out_stall;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall    <= $urandom_range(0, 19);
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                fade_result_t want;
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_ch.status, want.status));
                    if (out_ch.out_address !== want.out_address)
                        report_mismatch($sformatf("address %0d, expected %0d",
                                                  out_ch.out_address, want.out_address));
                    if (out_ch.out_level !== want.out_level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  out_ch.out_level, want.out_level));
                    if (out_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  out_ch.last, want.last));
                end
                out_stall    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                out_ch.ready <= 1'b0;
            end
            else if (out_stall > 0) begin
                out_stall    <= out_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || stimulus_done)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[channel_fade_engine_core] ERROR");
                $finish;
            end
        end
    end

    // Writes the fade time while the block is idle.
    task automatic write_fade_time(input logic [IVL_W-1:0] value);
        cfg_ch.fade_time_ms <= value;
        cfg_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        fade_time = value;
    endtask

    // Waits until every expected result has arrived, plus the tail of a walk.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic fade_item_t add_item(logic [ADDR_W-1:0] addr, logic [7:0] s,
                                            logic [7:0] t, logic [31:0] now);
        fade_item_t it;
        it.action          = ACT_ADD;
        it.channel_address = addr;
        it.start_level     = s;
        it.target_level    = t;
        it.time_ms         = now;
        return it;
    endfunction

    function automatic fade_item_t tick_item(logic [31:0] now);
        fade_item_t it;
        it = add_item(11'($urandom), 8'($urandom), 8'($urandom), now);
        it.action = ACT_TICK;
        return it;
    endfunction

    // Clears the table with a tick far in the future (no wrap in use).
    task automatic flush_table();
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        drain();
    endtask

    // Random phase: a random mix of adds and ticks at advancing times.
    task automatic random_phase(input int items, input logic [31:0] base);
        logic [31:0] now;
        int n;
        now = base;
        n = 0;
        while (n < items) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                logic [7:0] s;
                s = 8'($urandom);
                pending_items.push_back(add_item(11'($urandom), s,
                    ($urandom_range(0, 9) == 0) ? s : 8'($urandom), now));
                adds_sent++;
            end
            else begin
                now = now + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 5000)
                                                         : $urandom_range(0, 40));
                pending_items.push_back(tick_item(now));
                ticks_sent++;
            end
            n++;
        end
        drain();
    endtask

    initial begin
        fade_time = 22'd1000;
        for (int i = 0; i < NUM_FADES; i++)
            tbl_valid[i] = 1'b0;
        error_count   = 0;
        results_seen  = 0;
        ticks_sent    = 0;
        adds_sent     = 0;
        idle_cycles   = 0;
        stimulus_done = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.fade_time_ms = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset fade time, extremes, equal levels, catch-up, nothing due.
        pending_items.push_back(tick_item(32'd0));
        pending_items.push_back(add_item(11'd0, 8'd0, 8'd255, 32'd0));
        pending_items.push_back(add_item(11'h7FF, 8'd255, 8'd0, 32'd0));
        pending_items.push_back(add_item(11'd5, 8'd77, 8'd77, 32'd10));
        pending_items.push_back(add_item(11'h555, 8'd10, 8'd13, 32'd100));
        pending_items.push_back(tick_item(32'd3));
        pending_items.push_back(tick_item(32'd4));
        pending_items.push_back(tick_item(32'd500));
        pending_items.push_back(tick_item(32'd100000));
        drain();

        // Zero interval: jump straight to the target.
        write_fade_time(22'd0);
        pending_items.push_back(add_item(11'h2AA, 8'd0, 8'd255, 32'd50));
        pending_items.push_back(add_item(11'h155, 8'd200, 8'd199, 32'd50));
        pending_items.push_back(tick_item(32'd50));
        pending_items.push_back(tick_item(32'd51));
        drain();

        // Full table, then due time wrapping past 2^32 with maximum fade time.
        write_fade_time(22'h3FFFFF);
        for (int i = 0; i < NUM_FADES + 2; i++)
            pending_items.push_back(add_item(11'(i * 31), 8'(i), 8'(i + 1),
                                             32'hFFFF_FF00));
        pending_items.push_back(tick_item(32'hFFFF_FFFF));
        drain();
        flush_table();

        // Random phases under several fade times.
        write_fade_time(22'd100);
        random_phase(40, 32'd1000);
        flush_table();
        write_fade_time(22'd1);
        random_phase(30, 32'd20);
        flush_table();
        write_fade_time(22'($urandom_range(0, 3000)));
        random_phase(50, $urandom);
        stimulus_done = 1'b1;

        $display("covered %0d adds and %0d ticks in random phases, %0d results checked",
                 adds_sent, ticks_sent, results_seen);
        if (error_count == 0)
            $display("[channel_fade_engine_core] OK");
        else
            $display("[channel_fade_engine_core] ERROR");
        $finish;
    end

endmodule
